// ===== sv/shadow_memory_access_checker_assert.svh =====
// ----------------------------------------------------------------------------
// shadow memory access checker assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SHADOW_MEMORY_ACCESS_CHECKER_ASSERT_SVH
`define SHADOW_MEMORY_ACCESS_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS

// expression must never hold outside reset
`define SMAC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("shadow checker: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define SMAC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shadow checker: implication violated");

`else

`define SMAC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define SMAC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/smac_pkg.sv =====
// ----------------------------------------------------------------------------
// smac_pkg
// shared types and constants of the shadow memory access checker
// ----------------------------------------------------------------------------
package smac_pkg;

  // request field widths
  localparam int FUNC_W      = 2;
  localparam int ADDR_W      = 16;
  localparam int SIZE_W      = 9;
  localparam int SHADOW_W    = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // offset plus size plus rounding stays below 1024 for granules up to 256 bytes at MAX_SIZE 256
  localparam int SPAN_W = 10;
  localparam int CNT_W  = 10;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CHECK    = 2'd0,
    FUNC_POISON   = 2'd1,
    FUNC_UNPOISON = 2'd2,
    FUNC_READ     = 2'd3
  } func_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RUN,
    BK_WAIT,
    BK_RESULT
  } bk_state_t;

  // classified command, granule base travels next to it
  typedef struct packed {
    func_t                func;
    logic [SPAN_W-1:0]    span;
    logic [CNT_W-1:0]     count;
    logic [SHADOW_W-1:0]  fill;
    logic [SHADOW_W-1:0]  tail;
  } cmd_t;

  // conditions that hold off new requests
  typedef struct packed {
    logic q_full;
    logic clearing;
  } front_gate_t;

endpackage

// ===== sv/smac_front.sv =====
// ----------------------------------------------------------------------------
// smac_front
// accepts requests, clamps the size and turns each into a granule command
// ----------------------------------------------------------------------------
module smac_front
  import smac_pkg::*;
#(
  parameter int ADDR_BITS     = 16,
  parameter int GRANULE_SHIFT = 3,
  parameter int MAX_SIZE      = 256
) (
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [FUNC_W-1:0]                     in_func,
  input  logic [ADDR_W-1:0]                     in_addr,
  input  logic [SIZE_W-1:0]                     in_size,
  input  logic [SHADOW_W-1:0]                   in_magic,
  input  front_gate_t                           gate,
  output logic                                  push,
  output cmd_t                                  cmd,
  output logic [ADDR_BITS-GRANULE_SHIFT-1:0]    base
);

  localparam logic [SPAN_W-1:0] GRAN_BYTES = SPAN_W'(2 ** GRANULE_SHIFT);
  localparam logic [SPAN_W-1:0] GRAN_MASK  = GRAN_BYTES - SPAN_W'(1);

  logic [ADDR_BITS-1:0]     addr_w;
  logic [SIZE_W-1:0]        size_c;
  logic [SPAN_W-1:0]        span;
  logic [SPAN_W-1:0]        span_round;
  logic [SPAN_W-1:0]        size_round;
  logic [GRANULE_SHIFT-1:0] rem;
  func_t                    func;

  // handshake: hold off while the queue is full or the store is being filled
  assign in_tready = !gate.q_full && !gate.clearing;
  assign push      = in_tvalid && in_tready;

  // address within the modelled space and granule split
  assign addr_w = ADDR_BITS'(in_addr);
  assign base   = addr_w[ADDR_BITS-1:GRANULE_SHIFT];
  assign func   = func_t'(in_func);

  // size clamp
  always_comb begin
    if (32'(in_size) > 32'(MAX_SIZE)) begin
      size_c = SIZE_W'(MAX_SIZE);
    end else begin
      size_c = in_size;
    end
  end

  // granule counts
  assign span       = SPAN_W'(addr_w[GRANULE_SHIFT-1:0]) + SPAN_W'(size_c);
  assign span_round = span + GRAN_MASK;
  assign size_round = SPAN_W'(size_c) + GRAN_MASK;
  assign rem        = size_c[GRANULE_SHIFT-1:0];

  // classify
  always_comb begin
    cmd.func  = func;
    cmd.span  = span;
    cmd.count = CNT_W'(1);
    cmd.fill  = '0;
    cmd.tail  = '0;
    case (func)
      FUNC_CHECK: begin
        // zero size touches nothing
        if (size_c == '0) begin
          cmd.count = '0;
        end else begin
          cmd.count = CNT_W'(span_round >> GRANULE_SHIFT);
        end
      end
      FUNC_POISON: begin
        cmd.count = CNT_W'(size_round >> GRANULE_SHIFT);
        cmd.fill  = in_magic;
        cmd.tail  = in_magic;
      end
      FUNC_UNPOISON: begin
        // last granule takes the remainder, zero when the size is whole
        cmd.count = CNT_W'(size_round >> GRANULE_SHIFT);
        cmd.tail  = SHADOW_W'(rem);
      end
      FUNC_READ: begin
        cmd.count = CNT_W'(1);
      end
      default: begin
        cmd.count = CNT_W'(1);
      end
    endcase
  end

endmodule

// ===== sv/smac_queue.sv =====
// ----------------------------------------------------------------------------
// smac_queue
// small command fifo that decouples request intake from shadow walking
// ----------------------------------------------------------------------------
module smac_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  // depth must be a power of two so the pointers wrap on their own; the queue does not enforce it
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full  = (fill_r == CNT_W'(DEPTH));
  assign empty = (fill_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/smac_back.sv =====
// ----------------------------------------------------------------------------
// smac_back
// shadow store and sequencer: while a command walks its granules, one granule read or written per cycle
// ----------------------------------------------------------------------------
module smac_back
  import smac_pkg::*;
#(
  parameter int ADDR_BITS     = 16,
  parameter int GRANULE_SHIFT = 3,
  parameter int FILL_VALUE    = -3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  cmd_t                               q_cmd,
  input  logic [ADDR_BITS-GRANULE_SHIFT-1:0] q_base,
  output logic                               q_pop,
  output logic                               clearing,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic                               out_accessible,
  output logic [SHADOW_W-1:0]                out_shadow_byte
);

  localparam int                  GW         = ADDR_BITS - GRANULE_SHIFT;
  localparam int                  DEPTH      = 2 ** GW;
  localparam logic [SPAN_W-1:0]   GRAN_BYTES = SPAN_W'(2 ** GRANULE_SHIFT);
  localparam logic [SHADOW_W-1:0] FILL_BYTE  = SHADOW_W'(FILL_VALUE);

  // shadow store
  logic [SHADOW_W-1:0] mem [DEPTH];
  logic [SHADOW_W-1:0] rd_data_r;
  logic                mem_we;
  logic [SHADOW_W-1:0] mem_wdata;

  // sequencer state
  bk_state_t           state_r, state_nxt;
  logic [GW-1:0]       gran_r, gran_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SPAN_W-1:0]   rest_r, rest_nxt;
  func_t               func_r, func_nxt;
  logic [SHADOW_W-1:0] fill_r, fill_nxt;
  logic [SHADOW_W-1:0] tail_r, tail_nxt;
  logic                pend_r, pend_nxt;
  logic [SPAN_W-1:0]   hi_r, hi_nxt;
  logic                acc_r, acc_nxt;
  logic [SHADOW_W-1:0] sv_r, sv_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_acc_r, out_acc_nxt;
  logic [SHADOW_W-1:0] out_sv_r, out_sv_nxt;

  logic is_write;
  logic res_free;
  logic gran_ok;

  assign is_write = func_r inside {FUNC_POISON, FUNC_UNPOISON};
  assign res_free = !out_valid_r || out_tready;
  assign clearing = (state_r == BK_CLEAR);

  // granule passes when usable up to the highest touched byte
  assign gran_ok = !rd_data_r[SHADOW_W-1] &&
                   ((rd_data_r == '0) || (hi_r <= SPAN_W'(rd_data_r)));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (gran_r == '1) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_cmd.count == '0) ? BK_RESULT : BK_RUN;
        end
      end
      BK_RUN: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = is_write ? BK_RESULT : BK_WAIT;
        end
      end
      BK_WAIT: begin
        state_nxt = BK_RESULT;
      end
      BK_RESULT: begin
        if (res_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = FILL_BYTE;
    gran_nxt      = gran_r;
    cnt_nxt       = cnt_r;
    rest_nxt      = rest_r;
    func_nxt      = func_r;
    fill_nxt      = fill_r;
    tail_nxt      = tail_r;
    pend_nxt      = 1'b0;
    hi_nxt        = hi_r;
    acc_nxt       = acc_r;
    sv_nxt        = sv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_acc_nxt   = out_acc_r;
    out_sv_nxt    = out_sv_r;

    // fold in the granule read in the previous cycle
    if (pend_r) begin
      if (func_r == FUNC_CHECK) begin
        acc_nxt = acc_r && gran_ok;
      end else begin
        sv_nxt = rd_data_r;
      end
    end

    case (state_r)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = FILL_BYTE;
        gran_nxt  = gran_r + GW'(1);
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          gran_nxt = q_base;
          cnt_nxt  = q_cmd.count;
          rest_nxt = q_cmd.span;
          func_nxt = q_cmd.func;
          fill_nxt = q_cmd.fill;
          tail_nxt = q_cmd.tail;
          acc_nxt  = (q_cmd.func == FUNC_CHECK);
          sv_nxt   = '0;
        end
      end
      BK_RUN: begin
        if (is_write) begin
          mem_we    = 1'b1;
          mem_wdata = (cnt_r == CNT_W'(1)) ? tail_r : fill_r;
        end else begin
          // read issued this cycle, evaluated next cycle
          pend_nxt = 1'b1;
          hi_nxt   = (rest_r < GRAN_BYTES) ? rest_r : GRAN_BYTES;
          rest_nxt = rest_r - GRAN_BYTES;
        end
        gran_nxt = gran_r + GW'(1);
        cnt_nxt  = cnt_r - CNT_W'(1);
      end
      BK_WAIT: begin
        pend_nxt = 1'b0;
      end
      BK_RESULT: begin
        if (res_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = acc_r;
          out_sv_nxt    = sv_r;
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      gran_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gran_r      <= gran_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    rest_r    <= rest_nxt;
    func_r    <= func_nxt;
    fill_r    <= fill_nxt;
    tail_r    <= tail_nxt;
    hi_r      <= hi_nxt;
    acc_r     <= acc_nxt;
    sv_r      <= sv_nxt;
    out_acc_r <= out_acc_nxt;
    out_sv_r  <= out_sv_nxt;
  end

  // single port shadow store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[gran_r] <= mem_wdata;
    end
    rd_data_r <= mem[gran_r];
  end

  assign out_tvalid      = out_valid_r;
  assign out_accessible  = out_acc_r;
  assign out_shadow_byte = out_sv_r;

endmodule

// ===== sv/shadow_memory_access_checker.sv =====
// sequence: a check or read walks its granules in BK_RUN, then BK_WAIT, then BK_RESULT; a
// poison or unpoison writes in BK_RUN, then BK_RESULT; no granules skip to BK_RESULT
// throughput: one request at a time in the back end, set by the single shadow store port
// that moves one granule per cycle; a two-entry queue takes the next requests meanwhile
// reset: synchronous active-low rst_n, then all 2^(ADDR_BITS-GRANULE_SHIFT) store entries
// (8192 by default) are filled with FILL_VALUE while no request is taken
// ----------------------------------------------------------------------------
// shadow_memory_access_checker
// shadow byte store with check, poison, unpoison and read requests
// ----------------------------------------------------------------------------
`include "shadow_memory_access_checker_assert.svh"

module shadow_memory_access_checker
  import smac_pkg::*;
#(
  parameter int ADDR_BITS     = 16,
  parameter int GRANULE_SHIFT = 3,
  parameter int MAX_SIZE      = 256,
  parameter int FILL_VALUE    = -3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // addr [15:0], size [24:16], magic [32:25], zero [39:33]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func [1:0]
  input  logic [FUNC_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // accessible [0], shadow_byte [8:1], zero [15:9]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // done_res
  output logic                   out_tlast
);

  localparam int GW    = ADDR_BITS - GRANULE_SHIFT;
  localparam int CMD_W = $bits(cmd_t);
  localparam int Q_W   = CMD_W + GW;

  front_gate_t         gate;
  logic                q_push;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  logic                clearing;
  cmd_t                f_cmd;
  logic [GW-1:0]       f_base;
  logic [Q_W-1:0]      q_rdata;
  cmd_t                q_cmd;
  logic [GW-1:0]       q_base;
  logic                res_acc;
  logic [SHADOW_W-1:0] res_sv;

  assign gate.q_full   = q_full;
  assign gate.clearing = clearing;

  // request intake and classification
  smac_front #(
    .ADDR_BITS     (ADDR_BITS),
    .GRANULE_SHIFT (GRANULE_SHIFT),
    .MAX_SIZE      (MAX_SIZE)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .in_addr   (in_tdata[15:0]),
    .in_size   (in_tdata[24:16]),
    .in_magic  (in_tdata[32:25]),
    .gate      (gate),
    .push      (q_push),
    .cmd       (f_cmd),
    .base      (f_base)
  );

  // command queue
  smac_queue #(
    .W     (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_base, f_cmd}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_cmd  = cmd_t'(q_rdata[CMD_W-1:0]);
  assign q_base = q_rdata[Q_W-1:CMD_W];

  // shadow store walker
  smac_back #(
    .ADDR_BITS     (ADDR_BITS),
    .GRANULE_SHIFT (GRANULE_SHIFT),
    .FILL_VALUE    (FILL_VALUE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (q_cmd),
    .q_base          (q_base),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_accessible  (res_acc),
    .out_shadow_byte (res_sv)
  );

  // result packing, every result completes its request
  assign out_tdata = {7'd0, res_sv, res_acc};
  assign out_tlast = 1'b1;

  // checks
  `SMAC_ASSERT_NEVER(a_push_when_full, clk, rst_n, q_push && q_full)
  `SMAC_ASSERT_NEVER(a_pop_when_empty, clk, rst_n, q_pop && q_empty)
  `SMAC_ASSERT_IMPLY(a_no_intake_while_clearing, clk, rst_n, clearing, !in_tready)

endmodule
